/* src/lluf_pkg.sv */
// ----------------------------------------------------------------------------
// lluf_pkg
// Shared types, codes and helpers of the log line unescape/fold unit.
// ----------------------------------------------------------------------------
package lluf_pkg;

  localparam int COLUMN_BITS  = 16;
  localparam int MAX_RUN      = 14;
  localparam int CNT_BITS     = 4;   // holds 0..MAX_RUN
  localparam int IDX_BITS     = 4;   // addresses MAX_RUN entries
  localparam int WIDTH_BITS   = 10;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 10;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_INDENT     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FOLD_EN    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FOLD_WIDTH = 2'd2;

  localparam logic [WIDTH_BITS-1:0] FOLD_WIDTH_RST = 10'd80;

  // parser modes
  localparam logic [2:0] MODE_START     = 3'd0;
  localparam logic [2:0] MODE_TIME      = 3'd1;
  localparam logic [2:0] MODE_FIELDS    = 3'd2;
  localparam logic [2:0] MODE_MESSAGE   = 3'd3;
  localparam logic [2:0] MODE_BACKSLASH = 3'd4;

  // characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int TAB_COLS    = 8;
  localparam int INDENT_COLS = 4;

  typedef logic [COLUMN_BITS-1:0] col_t;
  localparam col_t COL_MAX = '1;

  typedef struct packed {
    logic [MAX_RUN-1:0][7:0] bytes;
    logic [CNT_BITS-1:0]     cnt;
  } run_t;

  typedef struct packed {
    run_t run;
    col_t col;
  } fold_t;

  // control from the top level to the parser
  typedef struct packed {
    logic                  advance;
    logic                  restart;
    logic                  indent;
    logic                  fold_en;
    logic [WIDTH_BITS-1:0] fold_width;
  } pctl_t;

  // parser status
  typedef struct packed {
    logic [2:0] mode;
    logic       col_zero;
    logic       tab;
  } pstat_t;

  function automatic run_t run_push(run_t r, logic [7:0] b);
    run_t o;
    o = r;
    if (r.cnt < CNT_BITS'(MAX_RUN)) begin
      o.bytes[r.cnt[IDX_BITS-1:0]] = b;
      o.cnt = r.cnt + 1'b1;
    end
    return o;
  endfunction

  function automatic col_t col_inc(col_t c);
    return (c == COL_MAX) ? c : c + 1'b1;
  endfunction

  // line break when the column sits exactly on the fold width
  function automatic fold_t fold_apply(run_t r, col_t c, logic tab, logic en,
                                       logic [WIDTH_BITS-1:0] w);
    fold_t f;
    f.run = r;
    f.col = c;
    if (en && (c == col_t'(w))) begin
      f.run = run_push(f.run, CH_NL);
      f.col = '0;
      if (tab) begin
        f.run = run_push(f.run, CH_TAB);
        f.col = col_t'(TAB_COLS);
      end
      f.run = run_push(f.run, CH_SPACE);
      f.run = run_push(f.run, CH_SPACE);
      f.run = run_push(f.run, CH_SPACE);
      f.run = run_push(f.run, CH_SPACE);
      f.col = f.col + col_t'(INDENT_COLS);
    end
    return f;
  endfunction

endpackage

/* src/lluf_in_if.sv */
// ----------------------------------------------------------------------------
// lluf_in_if
// Input byte channel.
// ----------------------------------------------------------------------------
interface lluf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

/* src/lluf_out_if.sv */
// ----------------------------------------------------------------------------
// lluf_out_if
// Output byte channel.
// ----------------------------------------------------------------------------
interface lluf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

/* src/lluf_cfg_if.sv */
// ----------------------------------------------------------------------------
// lluf_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface lluf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lluf_pkg::CFG_IDX_BITS-1:0]   index;
  logic [lluf_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/log_line_unescape_fold_unit.sv */
// ----------------------------------------------------------------------------
// log_line_unescape_fold_unit
// Formats a syslog-style byte stream: header parsing, unescape, line folding.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one raw byte per word (valid/ready).
//   out_ch : formatted bytes, one per word; run_last marks the final byte
//            produced by one input byte. Inputs that produce nothing give no
//            output word.
//   cfg_ch : register writes (0 indent_enable, 1 fold_enable, 2 fold_width),
//            always ready; write only while the unit is idle. Writing
//            indent_enable restarts the parser.
// Timing: an accepted byte is held in the input register, where the parser
//   plans its whole run; once the run buffer is free the run loads into it
//   and its first output word is valid. A run of up to 14 bytes goes out
//   one byte per accepted word, so single-byte runs stream at one byte per
//   cycle while out_ch is ready; draining the buffer paces expanding inputs.
// Backpressure: while out_ch stalls, the input register holds its byte and
//   in_ch.ready drops once it is full; bytes with empty runs still pass.
// Reset (rst_n low, synchronous): registers to defaults, parser in message
//   mode, column zero, no output pending.
// ----------------------------------------------------------------------------
module log_line_unescape_fold_unit (
  input  logic        clk,
  input  logic        rst_n,
  lluf_in_if.sink     in_ch,
  lluf_out_if.source  out_ch,
  lluf_cfg_if.sink    cfg_ch
);

  // configuration registers
  logic                           indent_r;
  logic                           fold_en_r;
  logic [lluf_pkg::WIDTH_BITS-1:0] fold_width_r;
  logic                           cfg_fire;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_ready;
  logic       consume;

  lluf_pkg::pctl_t  ctl;
  lluf_pkg::pstat_t stat;
  lluf_pkg::run_t   plan;
  logic             buf_free;
  logic             load;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      indent_r     <= 1'b0;
      fold_en_r    <= 1'b0;
      fold_width_r <= lluf_pkg::FOLD_WIDTH_RST;
    end else if (cfg_fire) begin
      case (cfg_ch.index)
        lluf_pkg::REG_INDENT:     indent_r     <= cfg_ch.data[0];
        lluf_pkg::REG_FOLD_EN:    fold_en_r    <= cfg_ch.data[0];
        lluf_pkg::REG_FOLD_WIDTH: fold_width_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // a byte leaves the input register when its run is empty or the run
  // buffer can take it this cycle
  assign consume  = in_valid_r && ((plan.cnt == '0) || buf_free);
  assign load     = consume && (plan.cnt != '0);
  assign in_ready = !in_valid_r || consume;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      in_byte_r <= in_ch.in_byte;
    end
  end

  // restart carries the value being written; otherwise the live register
  assign ctl.restart    = cfg_fire && (cfg_ch.index == lluf_pkg::REG_INDENT);
  assign ctl.indent     = ctl.restart ? cfg_ch.data[0] : indent_r;
  assign ctl.advance    = consume;
  assign ctl.fold_en    = fold_en_r;
  assign ctl.fold_width = fold_width_r;

  lluf_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl),
    .byte_i (in_byte_r),
    .plan_o (plan),
    .stat_o (stat)
  );

  lluf_run_buf u_run_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (load),
    .run_i       (plan),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_byte_o  (out_ch.out_byte),
    .run_last_o  (out_ch.run_last),
    .free_o      (buf_free)
  );

`ifndef SYNTHESIS
  // a byte waiting on the run buffer stays put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid_r && !consume |=> in_valid_r && $stable(in_byte_r))
    else $error("input register lost a pending byte");

  // restart puts the parser at the start of a record with an empty line
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && ctl.restart |=> stat.col_zero && !stat.tab &&
      (stat.mode == ($past(ctl.indent) ? lluf_pkg::MODE_START : lluf_pkg::MODE_MESSAGE)))
    else $error("parser not restarted by indent write");

  // a run goes out without gaps until its last byte
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_ch.valid && out_ch.ready && !out_ch.run_last |=> out_ch.valid)
    else $error("run broken before its last byte");

  // no plan exceeds the run buffer
  a_plan_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |-> plan.cnt <= lluf_pkg::CNT_BITS'(lluf_pkg::MAX_RUN))
    else $error("planned run longer than the buffer");
`endif

endmodule

/* src/lluf_parser.sv */
// ----------------------------------------------------------------------------
// lluf_parser
// Parser state and run planner: turns one byte into a run of output bytes.
// ----------------------------------------------------------------------------
module lluf_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  lluf_pkg::pctl_t   ctl_i,
  input  logic [7:0]        byte_i,
  output lluf_pkg::run_t    plan_o,
  output lluf_pkg::pstat_t  stat_o
);

  logic [2:0]     mode_r, mode_nxt;
  lluf_pkg::col_t col_r, col_nxt;
  logic           tab_r, tab_nxt;

  always_comb begin
    lluf_pkg::run_t  r;
    lluf_pkg::fold_t f;
    r        = '0;
    f        = '0;
    mode_nxt = mode_r;
    col_nxt  = col_r;
    tab_nxt  = tab_r;
    case (mode_r)
      lluf_pkg::MODE_START: begin
        if (byte_i == lluf_pkg::CH_QUOTE) begin
          mode_nxt = lluf_pkg::MODE_TIME;
        end else begin
          r       = lluf_pkg::run_push(r, byte_i);
          col_nxt = lluf_pkg::col_inc(col_r);
        end
      end
      lluf_pkg::MODE_TIME: begin
        if (byte_i == lluf_pkg::CH_QUOTE) begin
          mode_nxt = lluf_pkg::MODE_FIELDS;
        end
        r       = lluf_pkg::run_push(r, byte_i);
        col_nxt = lluf_pkg::col_inc(col_r);
      end
      lluf_pkg::MODE_FIELDS: begin
        if (byte_i == lluf_pkg::CH_QUOTE) begin
          // fields close: newline, fold check on the old column, then tab
          r = lluf_pkg::run_push(r, lluf_pkg::CH_NL);
          f = lluf_pkg::fold_apply(r, col_r, tab_r, ctl_i.fold_en, ctl_i.fold_width);
          r = lluf_pkg::run_push(f.run, lluf_pkg::CH_TAB);
          mode_nxt = lluf_pkg::MODE_MESSAGE;
          col_nxt  = '0;
          tab_nxt  = 1'b1;
        end else begin
          r       = lluf_pkg::run_push(r, byte_i);
          col_nxt = lluf_pkg::col_inc(col_r);
        end
      end
      lluf_pkg::MODE_BACKSLASH: begin
        mode_nxt = lluf_pkg::MODE_MESSAGE;
        if (byte_i == lluf_pkg::CH_BSL) begin
          f       = lluf_pkg::fold_apply(r, col_r, tab_r, ctl_i.fold_en, ctl_i.fold_width);
          r       = lluf_pkg::run_push(f.run, lluf_pkg::CH_BSL);
          col_nxt = lluf_pkg::col_inc(f.col);
        end else if (byte_i == lluf_pkg::CH_N) begin
          r = lluf_pkg::run_push(r, lluf_pkg::CH_NL);
          if (ctl_i.indent) begin
            r       = lluf_pkg::run_push(r, lluf_pkg::CH_TAB);
            col_nxt = lluf_pkg::col_t'(lluf_pkg::TAB_COLS);
            tab_nxt = 1'b1;
          end else begin
            col_nxt = '0;
          end
        end else if (byte_i != lluf_pkg::CH_R) begin
          // unknown escape passes through, each byte fold-checked
          f = lluf_pkg::fold_apply(r, col_r, tab_r, ctl_i.fold_en, ctl_i.fold_width);
          r = lluf_pkg::run_push(f.run, lluf_pkg::CH_BSL);
          f = lluf_pkg::fold_apply(r, lluf_pkg::col_inc(f.col), tab_r, ctl_i.fold_en,
                                   ctl_i.fold_width);
          r       = lluf_pkg::run_push(f.run, byte_i);
          col_nxt = lluf_pkg::col_inc(f.col);
        end
      end
      default: begin
        // message mode; unused codes behave the same
        if (byte_i == lluf_pkg::CH_BSL) begin
          mode_nxt = lluf_pkg::MODE_BACKSLASH;
        end else if (byte_i == lluf_pkg::CH_NL) begin
          r       = lluf_pkg::run_push(r, lluf_pkg::CH_NL);
          col_nxt = '0;
          tab_nxt = 1'b0;
        end else if (byte_i == lluf_pkg::CH_QUOTE) begin
          mode_nxt = ctl_i.indent ? lluf_pkg::MODE_START : lluf_pkg::MODE_MESSAGE;
          col_nxt  = '0;
          tab_nxt  = 1'b0;
        end else begin
          f       = lluf_pkg::fold_apply(r, col_r, tab_r, ctl_i.fold_en, ctl_i.fold_width);
          r       = lluf_pkg::run_push(f.run, byte_i);
          col_nxt = lluf_pkg::col_inc(f.col);
        end
      end
    endcase
    plan_o = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lluf_pkg::MODE_MESSAGE;
      col_r  <= '0;
      tab_r  <= 1'b0;
    end else if (ctl_i.restart) begin
      mode_r <= ctl_i.indent ? lluf_pkg::MODE_START : lluf_pkg::MODE_MESSAGE;
      col_r  <= '0;
      tab_r  <= 1'b0;
    end else if (ctl_i.advance) begin
      mode_r <= mode_nxt;
      col_r  <= col_nxt;
      tab_r  <= tab_nxt;
    end
  end

  assign stat_o.mode     = mode_r;
  assign stat_o.col_zero = (col_r == '0);
  assign stat_o.tab      = tab_r;

endmodule

/* src/lluf_run_buf.sv */
// ----------------------------------------------------------------------------
// lluf_run_buf
// Holds one planned run and hands it out one byte per accepted word.
// ----------------------------------------------------------------------------
module lluf_run_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load_i,
  input  lluf_pkg::run_t  run_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            free_o
);

  logic                                        valid_r;
  logic [lluf_pkg::MAX_RUN-1:0][7:0]           bytes_r;
  logic [lluf_pkg::CNT_BITS-1:0]               cnt_r;
  logic [lluf_pkg::IDX_BITS-1:0]               idx_r;
  logic                                        fire;
  logic                                        last;

  assign fire = valid_r && out_ready_i;
  assign last = (lluf_pkg::CNT_BITS'(idx_r) == cnt_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load_i) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (fire) begin
      if (last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      bytes_r <= run_i.bytes;
      cnt_r   <= run_i.cnt;
    end
  end

  assign out_valid_o = valid_r;
  assign out_byte_o  = bytes_r[idx_r];
  assign run_last_o  = last;
  assign free_o      = !valid_r || (fire && last);

endmodule

/* tb/lluf_format_watch.sv */
// ----------------------------------------------------------------------------
// lluf_format_watch
// Watches the byte, result and register channels of the unescape/fold unit.
// It keeps its own copy of the formatter state and the register settings,
// works out the output bytes of every accepted input byte, and compares each
// accepted output word with the oldest byte still due.
// ----------------------------------------------------------------------------
module lluf_format_watch
  import lluf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lluf_in_if   in_ch,
  lluf_out_if  out_ch,
  lluf_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } due_word_t;

  // register copies
  logic                  indent_on;
  logic                  fold_on;
  logic [WIDTH_BITS-1:0] wrap_width;

  // formatter state
  logic [2:0] mode;
  col_t       col;
  logic       tab;

  logic [7:0] run_q[$];
  due_word_t  due_bytes[$];
  due_word_t  want;

  initial fail_count = 0;
  initial pending = 0;

  task automatic report(input string msg);
    // quiet after the first hundred, the count still goes on
    if (fail_count < 100) $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void put(input logic [7:0] b);
    if (run_q.size() < MAX_RUN) run_q.push_back(b);
  endfunction

  function automatic void step_col();
    if (col != COL_MAX) col = col + 1'b1;
  endfunction

  // break before a byte that would land on the fold width
  function automatic void maybe_fold();
    if (fold_on && col == col_t'(wrap_width)) begin
      put(CH_NL);
      col = '0;
      if (tab) begin
        put(CH_TAB);
        col = col_t'(TAB_COLS);
      end
      repeat (INDENT_COLS) put(CH_SPACE);
      col = col + col_t'(INDENT_COLS);
    end
  endfunction

  function automatic void format_byte(input logic [7:0] b);
    run_q.delete();
    case (mode)
      MODE_START: begin
        if (b == CH_QUOTE) mode = MODE_TIME;
        else begin
          put(b);
          step_col();
        end
      end
      MODE_TIME: begin
        if (b == CH_QUOTE) mode = MODE_FIELDS;
        put(b);
        step_col();
      end
      MODE_FIELDS: begin
        if (b == CH_QUOTE) begin
          put(CH_NL);
          maybe_fold();
          mode = MODE_MESSAGE;
          put(CH_TAB);
          col = '0;
          tab = 1'b1;
        end else begin
          put(b);
          step_col();
        end
      end
      MODE_BACKSLASH: begin
        if (b == CH_BSL) begin
          maybe_fold();
          put(CH_BSL);
          step_col();
        end else if (b == CH_N) begin
          put(CH_NL);
          if (indent_on) begin
            put(CH_TAB);
            col = col_t'(TAB_COLS);
            tab = 1'b1;
          end else begin
            col = '0;
          end
        end else if (b != CH_R) begin
          maybe_fold();
          put(CH_BSL);
          step_col();
          maybe_fold();
          put(b);
          step_col();
        end
        mode = MODE_MESSAGE;
      end
      default: begin
        if (b == CH_BSL) begin
          mode = MODE_BACKSLASH;
        end else if (b == CH_NL) begin
          put(CH_NL);
          col = '0;
          tab = 1'b0;
        end else if (b == CH_QUOTE) begin
          mode = indent_on ? MODE_START : MODE_MESSAGE;
          col = '0;
          tab = 1'b0;
        end else begin
          maybe_fold();
          put(b);
          step_col();
        end
      end
    endcase
    foreach (run_q[i]) due_bytes.push_back('{run_q[i], i == run_q.size() - 1});
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      indent_on  = 1'b0;
      fold_on    = 1'b0;
      wrap_width = FOLD_WIDTH_RST;
      mode       = MODE_MESSAGE;
      col        = '0;
      tab        = 1'b0;
      due_bytes.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_INDENT: begin
            indent_on = cfg_ch.data[0];
            mode      = indent_on ? MODE_START : MODE_MESSAGE;
            col       = '0;
            tab       = 1'b0;
          end
          REG_FOLD_EN:    fold_on = cfg_ch.data[0];
          REG_FOLD_WIDTH: wrap_width = cfg_ch.data[WIDTH_BITS-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) format_byte(in_ch.in_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (due_bytes.size() == 0) begin
          report($sformatf("word %h last %b with nothing due",
                           out_ch.out_byte, out_ch.run_last));
        end else begin
          want = due_bytes.pop_front();
          if (out_ch.out_byte !== want.data)
            report($sformatf("out_byte %h, want %h", out_ch.out_byte, want.data));
          if (out_ch.run_last !== want.last)
            report($sformatf("run_last %b on byte %h, want %b",
                             out_ch.run_last, want.data, want.last));
        end
      end
    end
    pending = due_bytes.size();
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the log line unescape/fold unit.
// Directed records hit byte extremes, every escape, field close with and
// without a fold, the longest run and tiny fold widths; a stream of bytes
// with the column already past the fold width checks that only an exact
// match breaks a line; then random records, mostly well formed, run under
// several register settings with random gaps on the input and random stalls
// on the output.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lluf_pkg::*;

  localparam int LIMIT      = 2_000_000; // cycles before the run is declared hung
  localparam int SETTLE     = 4;         // input register plus planning slack
  localparam int DRAIN_WAIT = 20;        // one full run of 14 words and margin
  localparam int BURST      = 24;        // bytes streamed with the column past the width
  localparam int PHASES     = 6;
  localparam int PHASE_ITEMS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3; // unmapped index

  logic clk;
  logic rst_n;
  int   fail_total;
  int   pending;
  int   sent = 0;
  int   cycle_cnt = 0;
  bit   idle_on = 1'b1; // random gaps and stalls when set

  lluf_in_if  in_ch ();
  lluf_out_if out_ch ();
  lluf_cfg_if cfg_ch ();

  log_line_unescape_fold_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lluf_format_watch format_watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_total),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hang guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(10, 40);
  endfunction

  // Output side: ready drops for random stretches while idling is on.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_on) stall = pick_gap();
      end
    end
  end

  // A byte that the message parser passes straight through.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CH_QUOTE || b == CH_BSL || b == CH_NL);
    return b;
  endfunction

  // Offer one word on the input channel. Called at a falling edge; returns at
  // the falling edge after acceptance with valid still high, so back-to-back
  // words follow without a gap. Whoever pauses next lowers valid.
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic push_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) push_byte(seq[i]);
  endtask

  // Stop sending and let every due byte come out. A byte with an empty run
  // can still sit in the input register, so wait out the SETTLE margin too.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // One register write; only ever called with the unit idle.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // A record as the parser expects it: header (when indenting), then a message
  // mixing plain bytes, escapes, raw newlines and any byte at all, usually
  // closed by a quote and sometimes left open.
  task automatic send_record(input logic indent);
    int n;
    if (indent) begin
      push_byte(CH_QUOTE);
      n = $urandom_range(0, 5);
      repeat (n) push_byte(plain_byte());
      push_byte(CH_QUOTE);
      n = $urandom_range(0, 6);
      repeat (n) push_byte(plain_byte());
      push_byte(CH_QUOTE);
    end
    n = $urandom_range(0, 24);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          push_byte(CH_BSL);
          case ($urandom_range(0, 3))
            0:       push_byte(CH_N);
            1:       push_byte(CH_R);
            2:       push_byte(CH_BSL);
            default: push_byte(8'($urandom));
          endcase
        end
        3:       push_byte(CH_NL);
        4:       push_byte(8'($urandom));
        default: push_byte(plain_byte());
      endcase
    end
    if ($urandom_range(0, 9) != 0) push_byte(CH_QUOTE);
  endtask

  initial begin
    logic [CFG_DATA_BITS-1:0] val;
    logic [CFG_DATA_BITS-1:0] wid;
    logic                     ind;
    logic                     fen;
    int                       goal;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Unmapped register index must change nothing.
    write_reg(REG_SPARE, '1);

    // Reset settings: no header parsing, no folding. Byte extremes, a raw
    // newline, each escape kind, and a closing quote in message mode.
    push_seq('{8'h00, 8'hFF, CH_NL, CH_BSL, CH_N, CH_BSL, CH_R,
               CH_BSL, CH_BSL, CH_BSL, "q", CH_QUOTE});
    wait_idle();

    // Header parsing and folding at 13. Fields close on an empty header, an
    // escaped newline indents to column 8, five bytes reach 13, and an
    // unknown escape then folds twice: the longest run of fourteen words.
    write_reg(REG_INDENT, '1);
    write_reg(REG_FOLD_EN, 10'd1);
    write_reg(REG_FOLD_WIDTH, 10'd13);
    push_seq('{CH_QUOTE, CH_QUOTE, CH_QUOTE, CH_BSL, CH_N,
               "v", "w", "x", "y", "z", CH_BSL, "k", CH_QUOTE});
    wait_idle();

    // Fold width 1: fields close while the column sits on the width, so the
    // fold lands between the newline and the tab.
    write_reg(REG_FOLD_WIDTH, 10'd1);
    push_seq('{CH_QUOTE, CH_QUOTE, CH_QUOTE, "a", "b"});
    wait_idle();

    // Column past the width: get the column beyond it with folding off, then
    // fold on at 9 and keep streaming. Only an exact match breaks a line, so
    // no break may appear.
    write_reg(REG_INDENT, '0);
    write_reg(REG_FOLD_EN, '0);
    repeat (12) push_byte(plain_byte());
    wait_idle();
    write_reg(REG_FOLD_EN, 10'd1);
    write_reg(REG_FOLD_WIDTH, 10'd9);
    idle_on = 1'b0;
    repeat (BURST) push_byte(plain_byte());
    push_byte(CH_NL);
    wait_idle();
    idle_on = 1'b1;

    // Random records under several settings, width extremes among them.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin ind = 1'b1; fen = 1'b1; wid = 10'd9; end
        1:       begin ind = 1'b0; fen = 1'b1; wid = 10'd0; end
        2:       begin ind = 1'b1; fen = 1'b1; wid = '1; end
        3:       begin ind = 1'b1; fen = 1'b0; wid = 10'($urandom_range(9, 1023)); end
        4:       begin ind = 1'b0; fen = 1'b1; wid = 10'($urandom_range(9, 24)); end
        default: begin ind = 1'b1; fen = 1'b1; wid = 10'd13; end
      endcase
      wait_idle();
      // upper data bits are don't-care for the single-bit registers
      val = 10'($urandom);
      val[0] = ind;
      write_reg(REG_INDENT, val);
      val = 10'($urandom);
      val[0] = fen;
      write_reg(REG_FOLD_EN, val);
      write_reg(REG_FOLD_WIDTH, wid);
      goal = sent + PHASE_ITEMS;
      while (sent < goal) begin
        // some records run with no gaps or stalls at all
        idle_on = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
        end else begin
          send_record(ind);
        end
        // now and then hold off until every due byte is out
        if ($urandom_range(0, 19) == 0) wait_idle();
      end
    end
    idle_on = 1'b1;

    wait_idle();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_total == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
